>>> rtl/uer_pkg.sv
// ----------------------------------------------------------------------------
// uer_pkg
// Shared types and constants of the ultrasonic echo ranger.
// ----------------------------------------------------------------------------
package uer_pkg;

    localparam int CHANNELS_DEF   = 8;
    localparam int COUNT_BITS_DEF = 16;
    localparam int LINE_BITS      = 8;
    localparam logic [7:0] TRIG_RESET = 8'd10;
    localparam int CmDivisor = 58;
    localparam logic [7:0] DIST_MAX = 8'd255;
    localparam int QUEUE_DEPTH = 2;

    typedef enum logic [1:0] {
        ACT_START = 2'd0,
        ACT_EDGE  = 2'd1,
        ACT_TICK  = 2'd2,
        ACT_READ  = 2'd3
    } t_action;

    typedef enum logic [1:0] {
        ST_IDLE = 2'd0,
        ST_HIGH = 2'd1,
        ST_DONE = 2'd2,
        ST_ERR  = 2'd3
    } t_status;

    typedef struct packed {
        logic [1:0] action;
        logic [2:0] channel;
        logic       level;
    } t_in_item;

    typedef struct packed {
        logic [2:0] out_channel;
        logic [7:0] distance_cm;
        logic [1:0] channel_status;
        logic [7:0] trigger_lines;
        logic [7:0] armed_lines;
    } t_out_item;

    // Classified command handed from front to back.
    typedef struct packed {
        t_action    action;
        logic [2:0] channel;
        logic       level;
        logic       valid_ch;
    } t_cmd;

endpackage

>>> rtl/uer_front.sv
// ----------------------------------------------------------------------------
// uer_front
// Accepts input transactions, classifies them and queues them for the back end.
// ----------------------------------------------------------------------------
module uer_front #(
    parameter int CHANNELS = uer_pkg::CHANNELS_DEF
) (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  uer_pkg::t_in_item i_item,
    input  logic              push,
    output logic              full,
    output uer_pkg::t_cmd     o_cmd,
    output logic              o_cmd_valid,
    input  logic              i_cmd_take
);
    localparam int D = uer_pkg::QUEUE_DEPTH;

    uer_pkg::t_cmd r_q [D];
    logic          r_wp, r_rp;
    logic [1:0]    r_cnt;
    uer_pkg::t_cmd w_cmd;
    logic          w_wr, w_rd;

    always_comb begin
        w_cmd.action   = uer_pkg::t_action'(i_item.action);
        w_cmd.channel  = i_item.channel;
        w_cmd.level    = i_item.level;
        w_cmd.valid_ch = ({29'd0, i_item.channel} < 32'(CHANNELS));
    end

    assign full        = (r_cnt == 2'(D));
    assign w_wr        = push && !full;
    assign o_cmd_valid = (r_cnt != 2'd0);
    assign w_rd        = i_cmd_take && o_cmd_valid;
    assign o_cmd       = r_q[r_rp];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wp  <= 1'b0;
            r_rp  <= 1'b0;
            r_cnt <= 2'd0;
        end else begin
            if (w_wr) r_wp <= ~r_wp;
            if (w_rd) r_rp <= ~r_rp;
            r_cnt <= r_cnt + {1'b0, w_wr} - {1'b0, w_rd};
        end
        if (w_wr) r_q[r_wp] <= w_cmd;
    end
endmodule

>>> rtl/uer_back.sv
// ----------------------------------------------------------------------------
// uer_back
// Executes commands on per-channel state and queues the results.
// ----------------------------------------------------------------------------
module uer_back #(
    parameter int CHANNELS   = uer_pkg::CHANNELS_DEF,
    parameter int COUNT_BITS = uer_pkg::COUNT_BITS_DEF
) (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic [7:0]         i_trig_ticks,
    input  uer_pkg::t_cmd      i_cmd,
    input  logic               i_cmd_valid,
    output logic               o_cmd_take,
    output uer_pkg::t_out_item o_res,
    output logic               empty,
    input  logic               pop
);
    localparam int CW = (CHANNELS > 1) ? $clog2(CHANNELS) : 1;
    localparam int D  = uer_pkg::QUEUE_DEPTH;
    localparam logic [COUNT_BITS-1:0] CMAX = '1;

    // Reads saturate at 255, so only widths below 255 * 58 need an exact
    // quotient; floor(x / 58) = (x * 18079) >> 20 holds for every x below 2^14.
    localparam int DIV_SAT = 255 * uer_pkg::CmDivisor;
    localparam logic [14:0] DIV_MUL =
        15'(((1 << 20) + uer_pkg::CmDivisor - 1) / uer_pkg::CmDivisor);

    uer_pkg::t_status        r_st  [CHANNELS];
    logic [COUNT_BITS-1:0]   r_cnt [CHANNELS];
    logic [COUNT_BITS-1:0]   r_cap [CHANNELS];
    logic [7:0]              r_trm [CHANNELS];
    logic [CHANNELS-1:0]     r_arm;

    uer_pkg::t_status        n_st  [CHANNELS];
    logic [COUNT_BITS-1:0]   n_cnt [CHANNELS];
    logic [COUNT_BITS-1:0]   n_cap [CHANNELS];
    logic [7:0]              n_trm [CHANNELS];
    logic [CHANNELS-1:0]     n_arm;

    uer_pkg::t_out_item r_oq [D];
    logic       r_wp, r_rp;
    logic [1:0] r_ocnt;
    logic       w_go, w_rd;
    uer_pkg::t_out_item w_res;
    logic [CW-1:0] w_ch;
    logic [COUNT_BITS-1:0] w_capc;
    logic [32:0] w_capw;
    logic        w_sat;
    logic [28:0] w_prod;
    logic [7:0]  w_dist;

    assign w_ch   = CW'(i_cmd.channel);
    assign w_capc = r_cap[w_ch];
    assign w_capw = 33'(w_capc);
    assign w_sat  = (w_capw >= 33'(DIV_SAT));
    assign w_prod = 29'(w_capw[13:0]) * 29'(DIV_MUL);
    assign w_dist = w_sat ? uer_pkg::DIST_MAX : w_prod[27:20];

    assign o_cmd_take = (r_ocnt != 2'(D));
    assign w_go = i_cmd_valid && o_cmd_take;
    assign empty = (r_ocnt == 2'd0);
    assign w_rd = pop && !empty;
    assign o_res = r_oq[r_rp];

    always_comb begin
        for (int c = 0; c < CHANNELS; c++) begin
            n_st[c]  = r_st[c];
            n_cnt[c] = r_cnt[c];
            n_cap[c] = r_cap[c];
            n_trm[c] = r_trm[c];
        end
        n_arm = r_arm;
        w_res = '0;
        w_res.out_channel = i_cmd.channel;
        case (i_cmd.action)
            uer_pkg::ACT_START: begin
                if (i_cmd.valid_ch) begin
                    n_st[w_ch]  = uer_pkg::ST_IDLE;
                    n_trm[w_ch] = i_trig_ticks;
                    n_arm[w_ch] = (i_trig_ticks == 8'd0);
                end
            end
            uer_pkg::ACT_EDGE: begin
                if (i_cmd.valid_ch && r_arm[w_ch]) begin
                    if (i_cmd.level) begin
                        n_cnt[w_ch] = '0;
                        n_st[w_ch]  = uer_pkg::ST_HIGH;
                    end else if (r_st[w_ch] == uer_pkg::ST_HIGH) begin
                        n_cap[w_ch] = r_cnt[w_ch];
                        n_arm[w_ch] = 1'b0;
                        n_st[w_ch]  = uer_pkg::ST_DONE;
                    end else begin
                        n_st[w_ch]  = uer_pkg::ST_ERR;
                    end
                end
            end
            uer_pkg::ACT_TICK: begin
                for (int c = 0; c < CHANNELS; c++) begin
                    if (r_st[c] == uer_pkg::ST_HIGH && r_arm[c] && r_cnt[c] != CMAX)
                        n_cnt[c] = r_cnt[c] + 1'b1;
                    if (r_trm[c] != 8'd0) begin
                        n_trm[c] = r_trm[c] - 8'd1;
                        if (r_trm[c] == 8'd1) n_arm[c] = 1'b1;
                    end
                end
            end
            uer_pkg::ACT_READ: begin
                if (i_cmd.valid_ch) begin
                    n_arm[w_ch] = 1'b0;
                    n_trm[w_ch] = 8'd0;
                    case (r_st[w_ch])
                        uer_pkg::ST_IDLE: w_res.distance_cm = 8'd0;
                        uer_pkg::ST_DONE: w_res.distance_cm = w_dist;
                        default:          w_res.distance_cm = uer_pkg::DIST_MAX;
                    endcase
                end
            end
            default: ;
        endcase
        w_res.channel_status = i_cmd.valid_ch ? n_st[w_ch] : 2'd0;
        for (int c = 0; c < uer_pkg::LINE_BITS; c++) begin
            if (c < CHANNELS) begin
                w_res.trigger_lines[c] = (n_trm[c] != 8'd0);
                w_res.armed_lines[c]   = n_arm[c];
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int c = 0; c < CHANNELS; c++) begin
                r_st[c]  <= uer_pkg::ST_IDLE;
                r_cnt[c] <= '0;
                r_cap[c] <= '0;
                r_trm[c] <= 8'd0;
            end
            r_arm  <= '0;
            r_wp   <= 1'b0;
            r_rp   <= 1'b0;
            r_ocnt <= 2'd0;
        end else begin
            if (w_go) begin
                for (int c = 0; c < CHANNELS; c++) begin
                    r_st[c]  <= n_st[c];
                    r_cnt[c] <= n_cnt[c];
                    r_cap[c] <= n_cap[c];
                    r_trm[c] <= n_trm[c];
                end
                r_arm <= n_arm;
                r_wp  <= ~r_wp;
            end
            if (w_rd) r_rp <= ~r_rp;
            r_ocnt <= r_ocnt + {1'b0, w_go} - {1'b0, w_rd};
        end
        if (w_go) r_oq[r_wp] <= w_res;
    end
endmodule

>>> rtl/ultrasonic_echo_ranger_unit.sv
// ----------------------------------------------------------------------------
// ultrasonic_echo_ranger_unit
// Eight-channel ultrasonic echo timer with trigger pulses and distance reads.
// ----------------------------------------------------------------------------
//  channel   handshake          payload
//  input     push / full        i_item  (action, channel, level)
//  result    pop / empty        o_res   (channel, distance, status, lines)
//  config    i_cfg_valid/ready  i_cfg_data (trigger_ticks)
//
// One transaction per cycle sustained while results are popped; an accepted item
// enters the front queue, then the back-end state update writes its result
// into the result queue, from whose head o_res is driven.
// Two-entry queues on each side let input and output stall independently.
// Reset clears all channels to idle and trigger_ticks to 10.
// ----------------------------------------------------------------------------
module ultrasonic_echo_ranger_unit #(
    parameter int CHANNELS   = uer_pkg::CHANNELS_DEF,
    parameter int COUNT_BITS = uer_pkg::COUNT_BITS_DEF
) (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  uer_pkg::t_in_item  i_item,
    input  logic               push,
    output logic               full,
    output uer_pkg::t_out_item o_res,
    output logic               empty,
    input  logic               pop,
    input  logic               i_cfg_valid,
    output logic               o_cfg_ready,
    input  logic [7:0]         i_cfg_data
);
    logic [7:0]    r_trig;
    uer_pkg::t_cmd w_cmd;
    logic          w_cmd_valid, w_cmd_take;

    assign o_cfg_ready = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) r_trig <= uer_pkg::TRIG_RESET;
        else if (i_cfg_valid && o_cfg_ready) r_trig <= i_cfg_data;
    end

    uer_front #(.CHANNELS(CHANNELS)) u_front (
        .i_clk, .i_rst_n, .i_item, .push, .full,
        .o_cmd(w_cmd), .o_cmd_valid(w_cmd_valid), .i_cmd_take(w_cmd_take)
    );

    uer_back #(.CHANNELS(CHANNELS), .COUNT_BITS(COUNT_BITS)) u_back (
        .i_clk, .i_rst_n, .i_trig_ticks(r_trig),
        .i_cmd(w_cmd), .i_cmd_valid(w_cmd_valid), .o_cmd_take(w_cmd_take),
        .o_res, .empty, .pop
    );
endmodule
